// File: sv/fppi_pkg.sv
package fppi_pkg;

  // Angles are unsigned degrees with eight fraction bits, 0 to 360 inclusive.
  localparam int ANGLE_FRAC = 8;
  localparam int ANGLE_W    = 17;
  localparam int FULL_TURN  = 360 << ANGLE_FRAC;

  // Sine table entries are Q1.16 magnitudes; signed trig values carry one more bit.
  localparam int SINE_W = 17;
  localparam int TRIG_W = 18;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_LOOK_UP_LIMIT   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LOOK_DOWN_LIMIT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_START_X         = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_START_Y         = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_START_Z         = 3'd4;

  localparam logic [7:0] LIMIT_RESET = 8'd90;

  localparam logic [3:0] ACT_FWD      = 4'd0;
  localparam logic [3:0] ACT_BACK     = 4'd1;
  localparam logic [3:0] ACT_LEFT     = 4'd2;
  localparam logic [3:0] ACT_RIGHT    = 4'd3;
  localparam logic [3:0] ACT_FLY_FWD  = 4'd4;
  localparam logic [3:0] ACT_FLY_BACK = 4'd5;
  localparam logic [3:0] ACT_UP       = 4'd6;
  localparam logic [3:0] ACT_DOWN     = 4'd7;
  localparam logic [3:0] ACT_PITCH    = 4'd8;
  localparam logic [3:0] ACT_YAW      = 4'd9;
  localparam logic [3:0] ACT_PLACE    = 4'd10;

  // Pi in Q40 and the divisors (2n)(2n+1) of the sine series used to build the table.
  localparam logic [63:0] PI_Q40 = 64'h0000_0324_3F6A_8885;
  localparam logic [63:0] SERIES_DIV [12] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

  typedef struct packed {
    logic        [3:0]  action;
    logic signed [15:0] amount;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0]        pos_x;
    logic signed [31:0]        pos_y;
    logic signed [31:0]        pos_z;
    logic        [ANGLE_W-1:0] pitch_angle;
    logic        [ANGLE_W-1:0] yaw_angle;
  } pose_t;

  typedef struct packed {
    logic        [7:0]  look_up_limit;
    logic        [7:0]  look_down_limit;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
  } cfg_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_yaw;
    logic signed [TRIG_W-1:0] cos_yaw;
    logic signed [TRIG_W-1:0] sin_pitch;
  } trig_t;

endpackage

// File: sv/fppi_sine_rom.sv
module fppi_sine_rom #(
  parameter int SINE_STEPS_PER_DEGREE = 8
) (
  input  logic                                             clk,
  input  logic [$clog2(90*SINE_STEPS_PER_DEGREE+1)-1:0]    addr,
  output logic [fppi_pkg::SINE_W-1:0]                      data
);
  import fppi_pkg::*;

  localparam int Entries = 90 * SINE_STEPS_PER_DEGREE + 1;
  localparam logic [63:0] StepDiv = 64'(180 * SINE_STEPS_PER_DEGREE);

  typedef logic [SINE_W-1:0] rom_t [Entries];

  // Quarter-wave sine, entry k is sin(k steps) in Q1.16 rounded to nearest,
  // from a thirteen-term Taylor series in Q30.
  function automatic rom_t build_rom();
    rom_t        tab;
    logic [63:0] x;
    logic [63:0] term;
    longint      sum;
    longint      v;
    for (int k = 0; k < Entries; k++) begin
      x = (((64'(k) * PI_Q40) / StepDiv) + 64'd512) >> 10;
      sum = longint'(x);
      term = x;
      for (int n = 1; n <= 12; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / SERIES_DIV[n-1];
        if ((n % 2) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (sum + 64'sd8192) >>> 14;
      if (v > 65536) begin
        v = 65536;
      end
      tab[k] = SINE_W'(v);
    end
    return tab;
  endfunction

  localparam rom_t SineTable = build_rom();

  always_ff @(posedge clk) begin
    data <= SineTable[addr];
  end

endmodule

// File: sv/fppi_trig_fold.sv
module fppi_trig_fold #(
  parameter int SINE_STEPS_PER_DEGREE = 8
) (
  input  logic [fppi_pkg::ANGLE_W-1:0]                   angle,
  input  logic                                           shift_quarter,
  output logic [$clog2(90*SINE_STEPS_PER_DEGREE+1)-1:0]  addr,
  output logic                                           neg
);
  import fppi_pkg::*;

  localparam int QuarterSteps = 90 * SINE_STEPS_PER_DEGREE;
  localparam int TurnSteps    = 4 * QuarterSteps;
  localparam int StepsW       = $clog2(SINE_STEPS_PER_DEGREE + 1);
  localparam int ProdW        = ANGLE_W + StepsW;
  localparam int IdxW         = $clog2(TurnSteps + QuarterSteps + 1);
  localparam int AddrW        = $clog2(QuarterSteps + 1);
  localparam int RoundHalf    = 1 << (ANGLE_FRAC - 1);

  logic [ANGLE_W-1:0] r;
  logic [ProdW-1:0]   prod;
  logic [IdxW-1:0]    idx_raw;
  logic [IdxW-1:0]    idx_sh;
  logic [IdxW-1:0]    idx;

  always_comb begin
    // A full turn reads as zero; angles never exceed a full turn.
    r = (angle == ANGLE_W'(FULL_TURN)) ? '0 : angle;
    prod = ProdW'(r) * ProdW'(SINE_STEPS_PER_DEGREE);
    idx_raw = IdxW'((prod + ProdW'(RoundHalf)) >> ANGLE_FRAC);
    // Cosine is the sine one quarter of the table further on.
    idx_sh = idx_raw + (shift_quarter ? IdxW'(QuarterSteps) : '0);
    idx = (idx_sh >= IdxW'(TurnSteps)) ? idx_sh - IdxW'(TurnSteps) : idx_sh;

    if (idx < IdxW'(QuarterSteps)) begin
      addr = AddrW'(idx);
      neg = 1'b0;
    end else if (idx < IdxW'(2 * QuarterSteps)) begin
      addr = AddrW'(IdxW'(2 * QuarterSteps) - idx);
      neg = 1'b0;
    end else if (idx < IdxW'(3 * QuarterSteps)) begin
      addr = AddrW'(idx - IdxW'(2 * QuarterSteps));
      neg = 1'b1;
    end else begin
      addr = AddrW'(IdxW'(TurnSteps) - idx);
      neg = 1'b1;
    end
  end

endmodule

// File: sv/fppi_trig.sv
module fppi_trig #(
  parameter int SINE_STEPS_PER_DEGREE = 8
) (
  input  logic                         clk,
  input  logic [fppi_pkg::ANGLE_W-1:0] yaw,
  input  logic [fppi_pkg::ANGLE_W-1:0] pitch,
  output fppi_pkg::trig_t              trig
);
  import fppi_pkg::*;

  localparam int AddrW = $clog2(90 * SINE_STEPS_PER_DEGREE + 1);

  logic [AddrW-1:0]  addr_sy, addr_cy, addr_sp;
  logic              neg_sy_d, neg_cy_d, neg_sp_d;
  logic              neg_sy, neg_cy, neg_sp;
  logic [SINE_W-1:0] data_sy, data_cy, data_sp;
  logic signed [TRIG_W-1:0] mag_sy, mag_cy, mag_sp;

  fppi_trig_fold #(.SINE_STEPS_PER_DEGREE(SINE_STEPS_PER_DEGREE)) u_fold_sin_yaw (
    .angle(yaw), .shift_quarter(1'b0), .addr(addr_sy), .neg(neg_sy_d)
  );
  fppi_trig_fold #(.SINE_STEPS_PER_DEGREE(SINE_STEPS_PER_DEGREE)) u_fold_cos_yaw (
    .angle(yaw), .shift_quarter(1'b1), .addr(addr_cy), .neg(neg_cy_d)
  );
  fppi_trig_fold #(.SINE_STEPS_PER_DEGREE(SINE_STEPS_PER_DEGREE)) u_fold_sin_pitch (
    .angle(pitch), .shift_quarter(1'b0), .addr(addr_sp), .neg(neg_sp_d)
  );

  fppi_sine_rom #(.SINE_STEPS_PER_DEGREE(SINE_STEPS_PER_DEGREE)) u_rom_sin_yaw (
    .clk(clk), .addr(addr_sy), .data(data_sy)
  );
  fppi_sine_rom #(.SINE_STEPS_PER_DEGREE(SINE_STEPS_PER_DEGREE)) u_rom_cos_yaw (
    .clk(clk), .addr(addr_cy), .data(data_cy)
  );
  fppi_sine_rom #(.SINE_STEPS_PER_DEGREE(SINE_STEPS_PER_DEGREE)) u_rom_sin_pitch (
    .clk(clk), .addr(addr_sp), .data(data_sp)
  );

  // Signs are registered to line up with the registered table reads.
  always_ff @(posedge clk) begin
    neg_sy <= neg_sy_d;
    neg_cy <= neg_cy_d;
    neg_sp <= neg_sp_d;
  end

  always_comb begin
    mag_sy = $signed({1'b0, data_sy});
    mag_cy = $signed({1'b0, data_cy});
    mag_sp = $signed({1'b0, data_sp});
    trig.sin_yaw   = neg_sy ? -mag_sy : mag_sy;
    trig.cos_yaw   = neg_cy ? -mag_cy : mag_cy;
    trig.sin_pitch = neg_sp ? -mag_sp : mag_sp;
  end

endmodule

// File: sv/fppi_update.sv
module fppi_update (
  input  fppi_pkg::pose_t cur,
  input  fppi_pkg::cmd_t  cmd,
  input  fppi_pkg::trig_t trig,
  input  fppi_pkg::cfg_t  cfg,
  output fppi_pkg::pose_t nxt
);
  import fppi_pkg::*;

  localparam int DIST_W  = 17;
  localparam int PROD_W  = DIST_W + TRIG_W;
  localparam int STEP_W  = PROD_W - 8;
  localparam int ANG_S_W = ANGLE_W + 2;
  localparam int POS_SHIFT = 8;
  localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;

  // Q8.8 distance times Q1.16 trig, rounded to Q11.16 with ties toward plus infinity.
  function automatic logic signed [STEP_W-1:0] step_of(
    input logic signed [DIST_W-1:0] span,
    input logic signed [TRIG_W-1:0] t
  );
    logic signed [PROD_W-1:0] p;
    p = PROD_W'(span) * PROD_W'(t) + PROD_W'(128);
    return p[PROD_W-1:8];
  endfunction

  function automatic logic signed [31:0] sat_add(
    input logic signed [31:0]       base,
    input logic signed [STEP_W-1:0] delta
  );
    logic signed [32:0] s;
    s = 33'(base) + 33'(delta);
    if (s[32] != s[31]) begin
      return s[32] ? POS_MIN : POS_MAX;
    end
    return s[31:0];
  endfunction

  function automatic logic [ANGLE_W-1:0] wrap_angle(input logic signed [ANG_S_W-1:0] v);
    if (v > ANG_S_W'(FULL_TURN)) begin
      return ANGLE_W'(v - ANG_S_W'(FULL_TURN));
    end else if (v < 0) begin
      return ANGLE_W'(v + ANG_S_W'(FULL_TURN));
    end
    return ANGLE_W'(v);
  endfunction

  logic signed [DIST_W-1:0]  d, dd;
  logic signed [TRIG_W-1:0]  tx, tz;
  logic signed [STEP_W-1:0]  step_x, step_y, step_z, lift;
  logic signed [ANG_S_W-1:0] a, p, yaw_s, up_lim, down_lim, p_sum, p_res;

  always_comb begin
    d = DIST_W'($signed(cmd.amount));
    dd = (cmd.action == ACT_BACK || cmd.action == ACT_FLY_BACK) ? -d : d;
    // Strafing uses the heading turned a quarter left or right.
    tx = trig.sin_yaw;
    tz = trig.cos_yaw;
    if (cmd.action == ACT_LEFT) begin
      tx = -trig.cos_yaw;
      tz = trig.sin_yaw;
    end else if (cmd.action == ACT_RIGHT) begin
      tx = trig.cos_yaw;
      tz = -trig.sin_yaw;
    end
  end

  assign step_x = step_of(dd, tx);
  assign step_z = step_of(dd, tz);
  assign step_y = step_of(dd, trig.sin_pitch);
  assign lift   = STEP_W'(d) <<< POS_SHIFT;

  // The Q8.8 rotation amount is already in angle units and always within half a turn.
  always_comb begin
    a = ANG_S_W'($signed(cmd.amount));
    p = $signed({2'b00, cur.pitch_angle});
    yaw_s = $signed({2'b00, cur.yaw_angle});
    up_lim = (ANG_S_W'(360) - ANG_S_W'(cfg.look_up_limit)) <<< ANGLE_FRAC;
    down_lim = ANG_S_W'(cfg.look_down_limit) <<< ANGLE_FRAC;
    p_sum = p + a;
    p_res = p;
    // Turning past a limit the pitch sits on exactly leaves it where it is.
    if (a < 0) begin
      if (p < up_lim) begin
        p_res = p_sum;
      end else if (p > up_lim) begin
        p_res = (p_sum < up_lim) ? up_lim : p_sum;
      end
    end else if (a > 0) begin
      if (p < down_lim) begin
        p_res = (p_sum > down_lim) ? down_lim : p_sum;
      end else if (p > down_lim) begin
        p_res = p_sum;
      end
    end
  end

  always_comb begin
    nxt = cur;
    unique case (cmd.action) inside
      ACT_FWD, ACT_BACK, ACT_LEFT, ACT_RIGHT: begin
        nxt.pos_x = sat_add(cur.pos_x, -step_x);
        nxt.pos_z = sat_add(cur.pos_z, step_z);
      end
      ACT_FLY_FWD, ACT_FLY_BACK: begin
        nxt.pos_x = sat_add(cur.pos_x, -step_x);
        nxt.pos_y = sat_add(cur.pos_y, step_y);
        nxt.pos_z = sat_add(cur.pos_z, step_z);
      end
      ACT_UP:    nxt.pos_y = sat_add(cur.pos_y, -lift);
      ACT_DOWN:  nxt.pos_y = sat_add(cur.pos_y, lift);
      ACT_PITCH: nxt.pitch_angle = wrap_angle(p_res);
      ACT_YAW:   nxt.yaw_angle = wrap_angle(yaw_s + a);
      ACT_PLACE: begin
        nxt.pos_x = cfg.start_x;
        nxt.pos_y = cfg.start_y;
        nxt.pos_z = cfg.start_z;
      end
      default: nxt = cur;
    endcase
  end

endmodule

// File: sv/first_person_pose_integrator.sv
// Items pass through the command register into the pose register, which holds the result.
// Throughput: one item per cycle while the output side is not stalled; a pitch or yaw item
// stalls the next item while the registered sine table reads for the new angle.
// Reset (synchronous, active high) zeroes the pose, drops both handshakes and
// restores the look limits to 90 degrees and the start position to zero.
module first_person_pose_integrator #(
  parameter int SINE_STEPS_PER_DEGREE = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cmd_valid,
  output logic                               cmd_stall,
  input  fppi_pkg::cmd_t                     cmd,
  output logic                               pose_valid,
  input  logic                               pose_stall,
  output fppi_pkg::pose_t                    pose,
  input  logic                               cfg_we,
  input  logic [fppi_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [fppi_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import fppi_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd_q;
  logic  cmd_full;
  logic  trig_wait;
  logic  exec_go;
  pose_t pose_next;
  trig_t trig;

  // The pose register is both the state and the result register, so it only
  // changes when the output side is empty or being taken.
  assign exec_go   = cmd_full && !trig_wait && (!pose_valid || !pose_stall);
  assign cmd_stall = cmd_full && !exec_go;

  fppi_trig #(.SINE_STEPS_PER_DEGREE(SINE_STEPS_PER_DEGREE)) u_trig (
    .clk   (clk),
    .yaw   (pose.yaw_angle),
    .pitch (pose.pitch_angle),
    .trig  (trig)
  );

  fppi_update u_update (
    .cur  (pose),
    .cmd  (cmd_q),
    .trig (trig),
    .cfg  (cfg),
    .nxt  (pose_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_full   <= 1'b0;
      pose_valid <= 1'b0;
      trig_wait  <= 1'b1;
      pose       <= '0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        cmd_full <= 1'b1;
      end else if (exec_go) begin
        cmd_full <= 1'b0;
      end
      if (exec_go) begin
        pose_valid <= 1'b1;
        pose       <= pose_next;
      end else if (!pose_stall) begin
        pose_valid <= 1'b0;
      end
      trig_wait <= exec_go && (cmd_q.action == ACT_PITCH || cmd_q.action == ACT_YAW);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      cmd_q <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.look_up_limit   <= LIMIT_RESET;
      cfg.look_down_limit <= LIMIT_RESET;
      cfg.start_x         <= '0;
      cfg.start_y         <= '0;
      cfg.start_z         <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOOK_UP_LIMIT:   cfg.look_up_limit   <= cfg_data[7:0];
        REG_LOOK_DOWN_LIMIT: cfg.look_down_limit <= cfg_data[7:0];
        REG_START_X:         cfg.start_x         <= $signed(cfg_data);
        REG_START_Y:         cfg.start_y         <= $signed(cfg_data);
        REG_START_Z:         cfg.start_z         <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

endmodule
